// File: design/sobel_pkg.sv
package sobel_pkg;

  // Frame geometry limits
  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4096;
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned RowW      = $clog2(MaxHeight);
  localparam int unsigned WidthW    = ColW + 1;
  localparam int unsigned HeightW   = RowW + 1;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = HeightW;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IMAGE_WIDTH    = 2'd0,
    CFG_IMAGE_HEIGHT   = 2'd1,
    CFG_EDGE_THRESHOLD = 2'd2
  } cfg_idx_e;

  localparam logic [WidthW-1:0]  WidthReset     = WidthW'(256);
  localparam logic [HeightW-1:0] HeightReset    = HeightW'(256);
  localparam logic [7:0]         ThresholdReset = 8'd25;

  // Output codes
  localparam logic [7:0] EdgeOn  = 8'd255;
  localparam logic [7:0] EdgeOff = 8'd0;

  typedef struct packed {
    logic [7:0] pixel;
    logic       frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]      edge_pixel;
    logic            out_valid;
    logic [RowW-1:0] out_row;
    logic [ColW-1:0] out_col;
  } pix_out_t;

endpackage

// File: design/sobel_edge_threshold.sv
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+-----------------------------------
// in       | input     | in_valid_i / in_stall_o | in_data_i  (pixel, frame_start)
// out      | output    | out_valid_o / out_stall_i| out_data_o (edge_pixel, out_valid,
//          |           |                        |             out_row, out_col)
// cfg      | input     | cfg_we_i               | cfg_idx_i, cfg_wdata_i
//
// One pixel per clock unless stalled; results pass stage 1, then the output register.
// Stage 1 holds the line buffer read data; the output register holds the result.
// Reset clears counters and window and presets config; line buffers are not cleared.
// A stalled output holds stage 1, which then stalls the input; nothing is lost.
module sobel_edge_threshold (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  sobel_pkg::pix_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output sobel_pkg::pix_out_t       out_data_o,
  input  logic                      cfg_we_i,
  input  logic [sobel_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [sobel_pkg::CfgDataW-1:0] cfg_wdata_i
);
  import sobel_pkg::*;

  // Configuration registers
  logic [WidthW-1:0]  width_q;
  logic [HeightW-1:0] height_q;
  logic [16:0]        thr_sq_q;
  logic [8:0]         thr_p1;
  logic [17:0]        thr_sq_full;

  assign thr_p1      = {1'b0, cfg_wdata_i[7:0]} + 9'd1;
  assign thr_sq_full = thr_p1 * thr_p1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WidthReset;
      height_q <= HeightReset;
      thr_sq_q <= 17'(({9'd0, ThresholdReset} + 17'd1) * ({9'd0, ThresholdReset} + 17'd1));
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IMAGE_WIDTH:    width_q  <= cfg_wdata_i[WidthW-1:0];
        CFG_IMAGE_HEIGHT:   height_q <= cfg_wdata_i[HeightW-1:0];
        CFG_EDGE_THRESHOLD: thr_sq_q <= thr_sq_full[16:0];
        default: ;
      endcase
    end
  end

  // Effective sizes, saturated to the supported range
  logic [WidthW-1:0]  w_eff;
  logic [HeightW-1:0] h_eff;

  always_comb begin
    if (width_q < WidthW'(3))            w_eff = WidthW'(3);
    else if (width_q > WidthW'(MaxWidth)) w_eff = WidthW'(MaxWidth);
    else                                  w_eff = width_q;
    if (height_q < HeightW'(3))             h_eff = HeightW'(3);
    else if (height_q > HeightW'(MaxHeight)) h_eff = HeightW'(MaxHeight);
    else                                     h_eff = height_q;
  end

  // Handshake and pipeline control
  logic s1_v_q, out_v_q;
  logic out_free, s1_adv, in_acc;

  assign out_free   = !out_v_q || !out_stall_i;
  assign s1_adv     = s1_v_q && out_free;
  assign in_stall_o = s1_v_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Position counters (next pixel position)
  logic [ColW-1:0] col_q, col_cur;
  logic [RowW-1:0] row_q, row_cur;
  logic            last_col, last_row;

  assign col_cur  = in_data_i.frame_start ? '0 : col_q;
  assign row_cur  = in_data_i.frame_start ? '0 : row_q;
  assign last_col = ({1'b0, col_cur} + WidthW'(1)) >= w_eff;
  assign last_row = ({1'b0, row_cur} + HeightW'(1)) >= h_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_cur + RowW'(1);
      end else begin
        col_q <= col_cur + ColW'(1);
        row_q <= row_cur;
      end
    end
  end

  // Stage 1 registers
  logic [7:0]      s1_px_q;
  logic [ColW-1:0] s1_col_q;
  logic [RowW-1:0] s1_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (in_acc) begin
      s1_v_q <= 1'b1;
    end else if (s1_adv) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q  <= in_data_i.pixel;
      s1_col_q <= col_cur;
      s1_row_q <= row_cur;
    end
  end

  // Line buffers: written by stage 1, read at accept with registered data
  logic [7:0] lb_a [MaxWidth];
  logic [7:0] lb_b [MaxWidth];
  logic [7:0] rd_a_q, rd_b_q;
  logic [7:0] byp_a_q, byp_b_q;
  logic       byp_q;
  logic [7:0] top, mid, bot;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      lb_a[s1_col_q] <= s1_px_q;
      lb_b[s1_col_q] <= mid;
    end
    if (in_acc) begin
      rd_a_q <= lb_a[col_cur];
      rd_b_q <= lb_b[col_cur];
    end
  end

  // Bypass when the read hits the column being written in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (in_acc) begin
      byp_q <= s1_adv && (s1_col_q == col_cur);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byp_a_q <= s1_px_q;
      byp_b_q <= mid;
    end
  end

  assign top = byp_q ? byp_b_q : rd_b_q;
  assign mid = byp_q ? byp_a_q : rd_a_q;
  assign bot = s1_px_q;

  // 3x3 window: [0..2] column c-2, [3..5] column c-1; top, mid, bottom
  logic [7:0] win_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) win_q[i] <= '0;
    end else if (s1_adv) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top;
      win_q[4] <= mid;
      win_q[5] <= bot;
    end
  end

  // Sobel sums, divide by 8 toward zero, squared magnitude
  logic signed [10:0] sx, sy, sx_r, sy_r;
  logic signed [7:0]  qx, qy;
  logic signed [15:0] qx2, qy2;
  logic [15:0]        mag2;

  assign sx = (11'($signed({3'b0, top})) - 11'($signed({3'b0, win_q[0]})))
            + ((11'($signed({3'b0, mid})) - 11'($signed({3'b0, win_q[1]}))) <<< 1)
            + (11'($signed({3'b0, bot})) - 11'($signed({3'b0, win_q[2]})));
  assign sy = (11'($signed({3'b0, win_q[0]})) + (11'($signed({3'b0, win_q[3]})) <<< 1)
               + 11'($signed({3'b0, top})))
            - (11'($signed({3'b0, win_q[2]})) + (11'($signed({3'b0, win_q[5]})) <<< 1)
               + 11'($signed({3'b0, bot})));

  assign sx_r = (sx + (sx[10] ? 11'sd7 : 11'sd0)) >>> 3;
  assign sy_r = (sy + (sy[10] ? 11'sd7 : 11'sd0)) >>> 3;
  assign qx   = sx_r[7:0];
  assign qy   = sy_r[7:0];
  assign qx2  = qx * qx;
  assign qy2  = qy * qy;
  assign mag2 = {1'b0, qx2[14:0]} + {1'b0, qy2[14:0]};

  // Result assembly
  pix_out_t res;
  logic     has_ctr, interior;

  assign has_ctr  = (s1_row_q != '0) && (s1_col_q != '0);
  assign interior = (s1_row_q > RowW'(1)) && (s1_col_q > ColW'(1));

  always_comb begin
    res = '0;
    if (has_ctr) begin
      res.out_valid  = 1'b1;
      res.out_row    = s1_row_q - RowW'(1);
      res.out_col    = s1_col_q - ColW'(1);
      res.edge_pixel = (interior && ({1'b0, mag2} >= thr_sq_q)) ? EdgeOn : EdgeOff;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s1_adv) begin
      out_v_q <= 1'b1;
    end else if (out_free) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_o <= res;
    end
  end

  assign out_valid_o = out_v_q;

  // Checks
  a_edge_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.edge_pixel == EdgeOn || out_data_o.edge_pixel == EdgeOff))
    else $error("edge_pixel is neither on nor off");

  a_no_ctr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.out_valid) |->
      (out_data_o.edge_pixel == EdgeOff && out_data_o.out_row == '0 &&
       out_data_o.out_col == '0))
    else $error("result without centre carries nonzero fields");

  a_stall_needs_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_v_q && out_valid_o && out_stall_i))
    else $error("input stalled without a full pipeline");

  a_s1_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_stall_i) |=> out_valid_o)
    else $error("stage 1 item did not reach the output register");

endmodule

// File: test/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sobel_pkg::*;

  // One row of the directed stimulus; res is used only when typed is set
  typedef struct packed {
    logic [7:0] px;
    logic       fs;
    logic       typed;
    pix_out_t   res;
  } stim_row_t;

  localparam pix_out_t NoCentre = '0;

  // Width 3, height 4, threshold 0: 2 frames; borders, B (1,1) typed, rest predicted
  localparam stim_row_t DirTab [24] = '{
    // frame A, row 0: no centre yet
    '{8'd255, 1'b1, 1'b1, NoCentre},
    '{8'd0,   1'b0, 1'b1, NoCentre},
    '{8'd255, 1'b0, 1'b1, NoCentre},
    // row 1: centres in row 0 are border
    '{8'd0,   1'b0, 1'b1, NoCentre},
    '{8'd255, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd0, 10'd0}},
    '{8'd0,   1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd0, 10'd1}},
    // row 2: first interior centre
    '{8'd255, 1'b0, 1'b1, NoCentre},
    '{8'd0,   1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd1, 10'd0}},
    '{8'd255, 1'b0, 1'b0, NoCentre},
    // row 3: last row, then the row counter wraps
    '{8'd0,   1'b0, 1'b1, NoCentre},
    '{8'd255, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd2, 10'd0}},
    '{8'd0,   1'b0, 1'b0, NoCentre},
    // frame B: hard vertical step 0 | 128 | 255
    '{8'd0,   1'b1, 1'b1, NoCentre},
    '{8'd128, 1'b0, 1'b1, NoCentre},
    '{8'd255, 1'b0, 1'b1, NoCentre},
    '{8'd0,   1'b0, 1'b1, NoCentre},
    '{8'd128, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd0, 10'd0}},
    '{8'd255, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd0, 10'd1}},
    '{8'd0,   1'b0, 1'b1, NoCentre},
    '{8'd128, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd1, 10'd0}},
    '{8'd255, 1'b0, 1'b1, '{EdgeOn,  1'b1, 12'd1, 10'd1}},
    '{8'd255, 1'b0, 1'b1, NoCentre},
    '{8'd255, 1'b0, 1'b1, '{EdgeOff, 1'b1, 12'd2, 10'd0}},
    '{8'd255, 1'b0, 1'b0, NoCentre}
  };

  logic                clk_i;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  pix_in_t             in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pix_out_t            out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;

  sobel_edge_threshold uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state: own copy of config, line buffers, window and position
  logic [WidthW-1:0]  cfg_width  = WidthReset;
  logic [HeightW-1:0] cfg_height = HeightReset;
  logic [7:0]         cfg_thresh = ThresholdReset;
  logic [7:0]         prev_row_px  [MaxWidth];
  logic [7:0]         older_row_px [MaxWidth];
  logic [7:0]         win_px [6] = '{default: 8'd0};
  int unsigned        next_col = 0;
  int unsigned        next_row = 0;

  pix_out_t    edge_expect_q [$];
  pix_out_t    want_res;
  int unsigned err_count  = 0;
  int unsigned stall_left = 0;
  bit          calm       = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Sobel step on one pixel; updates predictor state, returns the result
  function automatic pix_out_t predict_edge(pix_in_t d);
    int unsigned w, h, c, r;
    logic [7:0]  top, mid, bot;
    int          sx, sy, qx, qy, mag2, t1;
    pix_out_t    res;
    w = (cfg_width < 3) ? 3 : (cfg_width > MaxWidth) ? MaxWidth : cfg_width;
    h = (cfg_height < 3) ? 3 : (cfg_height > MaxHeight) ? MaxHeight : cfg_height;
    res = '0;
    if (d.frame_start) begin
      next_col = 0;
      next_row = 0;
    end
    c = next_col;
    r = next_row;
    top = older_row_px[c];
    mid = prev_row_px[c];
    bot = d.pixel;
    if (r >= 1 && c >= 1) begin
      res.out_valid = 1'b1;
      res.out_row   = RowW'(r - 1);
      res.out_col   = ColW'(c - 1);
      // interior centre: taps [0..2] column c-2, [3..5] column c-1
      if (r >= 2 && c >= 2) begin
        sx = (int'(top) - int'(win_px[0])) + 2 * (int'(mid) - int'(win_px[1]))
           + (int'(bot) - int'(win_px[2]));
        sy = (int'(win_px[0]) + 2 * int'(win_px[3]) + int'(top))
           - (int'(win_px[2]) + 2 * int'(win_px[5]) + int'(bot));
        qx = sx / 8;  // truncates toward zero
        qy = sy / 8;
        mag2 = qx * qx + qy * qy;
        t1 = int'(cfg_thresh) + 1;
        if (mag2 >= t1 * t1) res.edge_pixel = EdgeOn;
      end
    end
    win_px[0] = win_px[3];
    win_px[1] = win_px[4];
    win_px[2] = win_px[5];
    win_px[3] = top;
    win_px[4] = mid;
    win_px[5] = bot;
    older_row_px[c] = mid;
    prev_row_px[c]  = bot;
    if (c + 1 >= w) begin
      next_col = 0;
      next_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
    end
    return res;
  endfunction

  // Drive one pixel transaction; stall is sampled at the falling edge
  task automatic send_pixel(input pix_in_t d, input bit use_typed, input pix_out_t typed_res);
    logic        stalled;
    pix_out_t    res;
    int unsigned gap;
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
    res = predict_edge(d);
    if (use_typed) res = typed_res;
    edge_expect_q.push_back(res);
    gap = calm ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the input off until every expected result has come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (edge_expect_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [WidthW-1:0] w, input logic [HeightW-1:0] h,
                            input logic [7:0] t);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_IMAGE_WIDTH;
    cfg_wdata_i <= CfgDataW'(w);
    @(posedge clk_i);
    cfg_width = w;
    cfg_idx_i   <= CFG_IMAGE_HEIGHT;
    cfg_wdata_i <= CfgDataW'(h);
    @(posedge clk_i);
    cfg_height = h;
    cfg_idx_i   <= CFG_EDGE_THRESHOLD;
    cfg_wdata_i <= CfgDataW'(t);
    @(posedge clk_i);
    cfg_thresh = t;
    cfg_we_i <= 1'b0;
  endtask

  // Output side: random stall, with calm stretches
  always @(posedge clk_i) begin
    if (stall_left == 0 && !calm && $urandom_range(0, 4) == 0) stall_left = pick_gap();
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (edge_expect_q.size() == 0) begin
        err_count++;
        if (err_count <= 10) $display("unexpected result: %p", out_data_o);
      end else begin
        want_res = edge_expect_q.pop_front();
        if (out_data_o.edge_pixel !== want_res.edge_pixel ||
            out_data_o.out_valid  !== want_res.out_valid  ||
            out_data_o.out_row    !== want_res.out_row    ||
            out_data_o.out_col    !== want_res.out_col) begin
          err_count++;
          if (err_count <= 10)
            $display("mismatch: exp e=%0d v=%0b r=%0d c=%0d, got e=%0d v=%0b r=%0d c=%0d",
                     want_res.edge_pixel, want_res.out_valid, want_res.out_row,
                     want_res.out_col, out_data_o.edge_pixel, out_data_o.out_valid,
                     out_data_o.out_row, out_data_o.out_col);
        end
      end
    end
  end

  // Stimulus
  initial begin
    pix_in_t            d;
    logic [WidthW-1:0]  w_raw;
    logic [HeightW-1:0] h_raw;
    logic [7:0]         t_raw, base;
    int unsigned        sent, phase, n_items, eff_w, eff_h, style, r;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    set_config(WidthW'(3), HeightW'(4), 8'd0);
    foreach (DirTab[i]) begin
      d.pixel       = DirTab[i].px;
      d.frame_start = DirTab[i].fs;
      send_pixel(d, DirTab[i].typed, DirTab[i].res);
    end
    wait_idle();

    // random part: one config setting per phase, each phase opens a frame
    sent  = 0;
    phase = 0;
    while (sent < 1700) begin
      calm = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 9);
      w_raw = (r == 0) ? WidthW'($urandom_range(0, 2)) :
              (r == 1) ? WidthW'($urandom_range(13, 40)) : WidthW'($urandom_range(3, 12));
      r = $urandom_range(0, 9);
      h_raw = (r == 0) ? HeightW'($urandom_range(0, 2)) :
              (r == 1) ? HeightW'($urandom_range(4097, 8191)) : HeightW'($urandom_range(3, 8));
      r = $urandom_range(0, 9);
      t_raw = (r < 2) ? 8'd0 : (r == 2) ? 8'd255 : 8'($urandom_range(0, 60));
      // settings at the extremes
      if (phase == 0) begin
        w_raw = '0;
        h_raw = '0;
        t_raw = 8'd0;
      end else if (phase == 1) begin
        w_raw = WidthW'(3);
        h_raw = '1;
        t_raw = 8'd255;
      end else if (phase == 2) begin
        w_raw = '1;  // saturates to the maximum width
        h_raw = HeightW'(3);
      end
      eff_w = (w_raw < 3) ? 3 : (w_raw > MaxWidth) ? MaxWidth : w_raw;
      eff_h = (h_raw < 3) ? 3 : (h_raw > MaxHeight) ? MaxHeight : h_raw;
      n_items = eff_w * eff_h * $urandom_range(1, 3) + $urandom_range(0, eff_w);
      if (n_items > 250) n_items = 250;
      if (phase == 2) n_items = MaxWidth + 6;
      style = $urandom_range(0, 2);
      base  = 8'($urandom_range(0, 255));

      wait_idle();
      set_config(w_raw, h_raw, t_raw);
      for (int unsigned k = 0; k < n_items; k++) begin
        case (style)
          0: d.pixel = 8'($urandom_range(0, 255));
          1: d.pixel = base ^ 8'($urandom_range(0, 15));  // small gradients
          default: d.pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        endcase
        d.frame_start = (k == 0) || ($urandom_range(0, 149) == 0);
        send_pixel(d, 1'b0, NoCentre);
        sent++;
        // let the output side catch up completely once mid-stream
        if (phase == 2 && k == 500) wait_idle();
      end
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
